/* hw/rtl/hllf_pkg.sv */
`default_nettype none

package hllf_pkg;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int UW = DW - 1;
	localparam int GW = 18;
	localparam int NC = 5;
	localparam int NUM_W = DW + FB;
	localparam int RT_W = NUM_W / 2;
	localparam int DIV_LAT = NUM_W + 2;
	localparam int SQRT_LAT = RT_W + 1;
	localparam int SC = 1 + DIV_LAT + SQRT_LAT;
	localparam int SIDE_DLY = SC - 3;
	localparam int LAT = SC + 5 + DIV_LAT + 1;

	localparam logic [GW-1:0] GAMMA_RST = GW'(109227);
	localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

	typedef logic signed [DW-1:0] fx_word_t;

	typedef struct packed {
		fx_word_t v;
		logic     o;
	} fx_res_t;

	typedef struct packed {
		fx_word_t [NC-1:0] f;
		fx_word_t [NC-1:0] u;
		fx_word_t          vx;
		logic              o;
	} side_t;

	typedef struct packed {
		fx_word_t [NC-1:0] fl;
		logic              zero;
		logic              opre;
		logic              oc;
	} fin_t;

	function automatic logic [DW-1:0] fx_mag(input fx_word_t a);
		logic [DW-1:0] m;
		m = a[DW-1] ? (~a + 1'b1) : a;
		return m;
	endfunction

	function automatic fx_res_t sat_mag(input logic neg, input logic [NUM_W-1:0] m);
		logic [NUM_W-1:0] lim;
		fx_res_t r;
		lim = NUM_W'($unsigned(VMAX)) + NUM_W'(neg);
		if (m > lim) begin
			r.v = neg ? VMIN : VMAX;
			r.o = 1'b1;
		end else begin
			r.v = neg ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
			r.o = 1'b0;
		end
		return r;
	endfunction

	function automatic fx_res_t fx_mul(input fx_word_t a, input fx_word_t b);
		logic [2*DW-1:0] p;
		p = fx_mag(a) * fx_mag(b);
		return sat_mag(a[DW-1] ^ b[DW-1], p[2*DW-1:FB]);
	endfunction

	function automatic fx_res_t fx_add(input fx_word_t a, input fx_word_t b);
		logic signed [DW:0] s;
		fx_res_t r;
		s = (DW+1)'(a) + (DW+1)'(b);
		if (s[DW] != s[DW-1]) begin
			r.v = s[DW] ? VMIN : VMAX;
			r.o = 1'b1;
		end else begin
			r.v = s[DW-1:0];
			r.o = 1'b0;
		end
		return r;
	endfunction

	function automatic fx_res_t fx_sub(input fx_word_t a, input fx_word_t b);
		logic signed [DW:0] s;
		fx_res_t r;
		s = (DW+1)'(a) - (DW+1)'(b);
		if (s[DW] != s[DW-1]) begin
			r.v = s[DW] ? VMIN : VMAX;
			r.o = 1'b1;
		end else begin
			r.v = s[DW-1:0];
			r.o = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/hllf_div.sv */
`default_nettype none

module hllf_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [hllf_pkg::DW-1:0] a,
	input  logic signed [hllf_pkg::DW-1:0] b,
	output logic signed [hllf_pkg::DW-1:0] q,
	output logic                           ovf
);
	import hllf_pkg::*;

	logic [NUM_W-1:0] num_s [0:NUM_W];
	logic [DW-1:0]    den_s [0:NUM_W];
	logic [DW-1:0]    rem_s [0:NUM_W];
	logic [NUM_W-1:0] quo_s [0:NUM_W];
	logic             neg_s [0:NUM_W];
	logic             dz_s  [0:NUM_W];
	fx_word_t         dzv_s [0:NUM_W];
	logic             dzo_s [0:NUM_W];
	fx_res_t          sat_w;

	// operand prep and divide-by-zero result
	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= {fx_mag(a), FB'(0)};
			den_s[0] <= fx_mag(b);
			rem_s[0] <= '0;
			quo_s[0] <= '0;
			neg_s[0] <= a[DW-1] ^ b[DW-1];
			dz_s[0]  <= (b == '0);
			dzv_s[0] <= (a == '0) ? '0 : (a[DW-1] ? VMIN : VMAX);
			dzo_s[0] <= (a != '0);
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= NUM_W; k++) begin : g_step
		logic [DW:0] t;
		logic        ge;
		assign t  = {rem_s[k-1], num_s[k-1][NUM_W-k]};
		assign ge = (t >= {1'b0, den_s[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= num_s[k-1];
				den_s[k] <= den_s[k-1];
				rem_s[k] <= ge ? DW'(t - {1'b0, den_s[k-1]}) : t[DW-1:0];
				quo_s[k] <= {quo_s[k-1][NUM_W-2:0], ge};
				neg_s[k] <= neg_s[k-1];
				dz_s[k]  <= dz_s[k-1];
				dzv_s[k] <= dzv_s[k-1];
				dzo_s[k] <= dzo_s[k-1];
			end
		end
	end

	assign sat_w = sat_mag(neg_s[NUM_W], quo_s[NUM_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dz_s[NUM_W]) begin
				q   <= dzv_s[NUM_W];
				ovf <= dzo_s[NUM_W];
			end else begin
				q   <= sat_w.v;
				ovf <= sat_w.o;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/hllf_sqrt.sv */
`default_nettype none

module hllf_sqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [hllf_pkg::DW-1:0] a,
	output logic signed [hllf_pkg::DW-1:0] q
);
	import hllf_pkg::*;

	logic [NUM_W-1:0] x_s    [0:RT_W];
	logic [RT_W+1:0]  rem_s  [0:RT_W];
	logic [RT_W-1:0]  root_s [0:RT_W];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= a[DW-1] ? '0 : {a, FB'(0)};
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	// one root bit per stage
	for (genvar k = 1; k <= RT_W; k++) begin : g_step
		logic [RT_W+3:0] t;
		logic [RT_W+3:0] trial;
		logic            ge;
		assign t     = {rem_s[k-1], x_s[k-1][2*(RT_W-k)+1 -: 2]};
		assign trial = (RT_W+4)'({root_s[k-1], 2'b01});
		assign ge    = (t >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_s[k-1];
				rem_s[k]  <= ge ? (RT_W+2)'(t - trial) : t[RT_W+1:0];
				root_s[k] <= {root_s[k-1][RT_W-2:0], ge};
			end
		end
	end

	assign q = fx_word_t'({(DW-RT_W)'(0), root_s[RT_W]});

endmodule

`default_nettype wire

/* hw/rtl/hll_euler_interface_flux_unit.sv */
// throughput: one transaction per cycle unless out_stall holds a result;
// depth is set by the bit-per-stage
// dividers (sound speed and flux normalization) and the square root
// reset: clears all pipeline valid bits, adiabatic_index returns to 109227
`default_nettype none

module hll_euler_interface_flux_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [hllf_pkg::GW-1:0]        cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [hllf_pkg::UW-1:0]        density_left,
	input  logic signed [hllf_pkg::DW-1:0] velocity_x_left,
	input  logic signed [hllf_pkg::DW-1:0] velocity_y_left,
	input  logic signed [hllf_pkg::DW-1:0] velocity_z_left,
	input  logic [hllf_pkg::UW-1:0]        pressure_left,
	input  logic [hllf_pkg::UW-1:0]        energy_left,
	input  logic [hllf_pkg::UW-1:0]        density_right,
	input  logic signed [hllf_pkg::DW-1:0] velocity_x_right,
	input  logic signed [hllf_pkg::DW-1:0] velocity_y_right,
	input  logic signed [hllf_pkg::DW-1:0] velocity_z_right,
	input  logic [hllf_pkg::UW-1:0]        pressure_right,
	input  logic [hllf_pkg::UW-1:0]        energy_right,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [hllf_pkg::DW-1:0] flux_mass,
	output logic signed [hllf_pkg::DW-1:0] flux_momentum_x,
	output logic signed [hllf_pkg::DW-1:0] flux_momentum_y,
	output logic signed [hllf_pkg::DW-1:0] flux_momentum_z,
	output logic signed [hllf_pkg::DW-1:0] flux_energy,
	output logic                           overflow
);
	import hllf_pkg::*;

	logic [GW-1:0]  gamma_q;
	logic [LAT-1:0] valid_q;
	logic           en;

	fx_word_t rho_i [2];
	fx_word_t vx_i  [2];
	fx_word_t vy_i  [2];
	fx_word_t vz_i  [2];
	fx_word_t p_i   [2];
	fx_word_t e_i   [2];

	fx_res_t  mu1 [2];
	fx_res_t  mu2 [2];
	fx_res_t  mu3 [2];
	fx_res_t  mgp [2];
	fx_res_t  aep [2];

	fx_word_t rho_s1 [2];
	fx_word_t vx_s1  [2];
	fx_word_t p_s1   [2];
	fx_word_t e_s1   [2];
	fx_word_t u1_s1  [2];
	fx_word_t u2_s1  [2];
	fx_word_t u3_s1  [2];
	fx_word_t gp_s1  [2];
	fx_word_t ep_s1  [2];
	logic     o_s1   [2];

	fx_res_t  mf1 [2];
	fx_res_t  mf2 [2];
	fx_res_t  mf3 [2];
	fx_res_t  mf4 [2];

	fx_word_t rho_s2 [2];
	fx_word_t vx_s2  [2];
	fx_word_t p_s2   [2];
	fx_word_t e_s2   [2];
	fx_word_t u1_s2  [2];
	fx_word_t u2_s2  [2];
	fx_word_t u3_s2  [2];
	fx_word_t f1a_s2 [2];
	fx_word_t f2_s2  [2];
	fx_word_t f3_s2  [2];
	fx_word_t f4_s2  [2];
	logic     o_s2   [2];

	fx_res_t  af1 [2];
	side_t    side_s3 [2];
	side_t    side_dly_q [2][SIDE_DLY];

	fx_word_t gq_w [2];
	logic     go_w [2];
	fx_word_t c_w  [2];
	logic     divo_dly_q [2][SQRT_LAT];

	side_t    sd [2];
	fx_res_t  ar_c, br_c, al_c, bl_c;

	fx_word_t ar_s4, br_s4, al_s4, bl_s4;
	fx_word_t [NC-1:0] fl_s4, fr_s4, ul_s4, ur_s4;
	logic     o_s4;

	fx_word_t sr_c, sl_c;
	fx_res_t  du_c [NC];
	logic     du_o;

	fx_word_t sr_s5, sl_s5;
	fx_word_t [NC-1:0] fl_s5, fr_s5, du_s5;
	logic     o_s5, oc_s5;

	fx_res_t  p1_c [NC];
	fx_res_t  p2_c [NC];
	fx_res_t  srsl_c, den_c;
	logic     p_o;

	fx_word_t [NC-1:0] p1_s6, p2_s6, du_s6, fl_s6;
	fx_word_t srsl_s6, den_s6;
	logic     zero_s6, opre_s6, oc_s6;

	fx_res_t  m1_c [NC];
	fx_res_t  p3_c [NC];
	logic     m1_o;

	fx_word_t [NC-1:0] m1_s7, p3_s7, fl_s7;
	fx_word_t den_s7;
	logic     zero_s7, opre_s7, oc_s7;

	fx_res_t  m_c [NC];
	logic     m_o;

	fx_word_t [NC-1:0] m_s8, fl_s8;
	fx_word_t den_s8;
	logic     zero_s8, opre_s8, oc_s8;

	fin_t     fin_dly_q [DIV_LAT];
	fin_t     fin_w;
	fx_word_t dq_w [NC];
	logic     [NC-1:0] do_w;

	fx_word_t [NC-1:0] flux_q;
	logic     overflow_q;

	// whole pipeline advances unless a finished result is held
	assign en        = !valid_q[LAT-1] || !out_stall;
	assign in_stall  = !en;
	assign out_valid = valid_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RST;
		end else if (cfg_write) begin
			gamma_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT-2:0], in_valid};
		end
	end

	assign rho_i[0] = fx_word_t'({1'b0, density_left});
	assign rho_i[1] = fx_word_t'({1'b0, density_right});
	assign vx_i[0]  = velocity_x_left;
	assign vx_i[1]  = velocity_x_right;
	assign vy_i[0]  = velocity_y_left;
	assign vy_i[1]  = velocity_y_right;
	assign vz_i[0]  = velocity_z_left;
	assign vz_i[1]  = velocity_z_right;
	assign p_i[0]   = fx_word_t'({1'b0, pressure_left});
	assign p_i[1]   = fx_word_t'({1'b0, pressure_right});
	assign e_i[0]   = fx_word_t'({1'b0, energy_left});
	assign e_i[1]   = fx_word_t'({1'b0, energy_right});

	// side stage 1: momenta, gamma*p, e+p
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			mu1[s] = fx_mul(rho_i[s], vx_i[s]);
			mu2[s] = fx_mul(rho_i[s], vy_i[s]);
			mu3[s] = fx_mul(rho_i[s], vz_i[s]);
			mgp[s] = fx_mul(fx_word_t'(DW'(gamma_q)), p_i[s]);
			aep[s] = fx_add(e_i[s], p_i[s]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < 2; s++) begin
				rho_s1[s] <= rho_i[s];
				vx_s1[s]  <= vx_i[s];
				p_s1[s]   <= p_i[s];
				e_s1[s]   <= e_i[s];
				u1_s1[s]  <= mu1[s].v;
				u2_s1[s]  <= mu2[s].v;
				u3_s1[s]  <= mu3[s].v;
				gp_s1[s]  <= mgp[s].v;
				ep_s1[s]  <= aep[s].v;
				o_s1[s]   <= mu1[s].o | mu2[s].o | mu3[s].o | mgp[s].o | aep[s].o;
			end
		end
	end

	// side stage 2: flux products
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			mf1[s] = fx_mul(u1_s1[s], vx_s1[s]);
			mf2[s] = fx_mul(u2_s1[s], vx_s1[s]);
			mf3[s] = fx_mul(u3_s1[s], vx_s1[s]);
			mf4[s] = fx_mul(ep_s1[s], vx_s1[s]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < 2; s++) begin
				rho_s2[s] <= rho_s1[s];
				vx_s2[s]  <= vx_s1[s];
				p_s2[s]   <= p_s1[s];
				e_s2[s]   <= e_s1[s];
				u1_s2[s]  <= u1_s1[s];
				u2_s2[s]  <= u2_s1[s];
				u3_s2[s]  <= u3_s1[s];
				f1a_s2[s] <= mf1[s].v;
				f2_s2[s]  <= mf2[s].v;
				f3_s2[s]  <= mf3[s].v;
				f4_s2[s]  <= mf4[s].v;
				o_s2[s]   <= o_s1[s] | mf1[s].o | mf2[s].o | mf3[s].o | mf4[s].o;
			end
		end
	end

	// side stage 3: pack side flux and conserved vector
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			af1[s] = fx_add(f1a_s2[s], p_s2[s]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < 2; s++) begin
				side_s3[s].f[0] <= u1_s2[s];
				side_s3[s].f[1] <= af1[s].v;
				side_s3[s].f[2] <= f2_s2[s];
				side_s3[s].f[3] <= f3_s2[s];
				side_s3[s].f[4] <= f4_s2[s];
				side_s3[s].u[0] <= rho_s2[s];
				side_s3[s].u[1] <= u1_s2[s];
				side_s3[s].u[2] <= u2_s2[s];
				side_s3[s].u[3] <= u3_s2[s];
				side_s3[s].u[4] <= e_s2[s];
				side_s3[s].vx   <= vx_s2[s];
				side_s3[s].o    <= o_s2[s] | af1[s].o;
			end
		end
	end

	// sound speed: sqrt(gamma*p/rho)
	for (genvar s = 0; s < 2; s++) begin : g_side
		hllf_div u_div (
			.clk (clk),
			.en  (en),
			.a   (gp_s1[s]),
			.b   (rho_s1[s]),
			.q   (gq_w[s]),
			.ovf (go_w[s])
		);

		hllf_sqrt u_sqrt (
			.clk (clk),
			.en  (en),
			.a   (gq_w[s]),
			.q   (c_w[s])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < 2; s++) begin
				side_dly_q[s][0] <= side_s3[s];
				for (int j = 1; j < SIDE_DLY; j++) begin
					side_dly_q[s][j] <= side_dly_q[s][j-1];
				end
				divo_dly_q[s][0] <= go_w[s];
				for (int j = 1; j < SQRT_LAT; j++) begin
					divo_dly_q[s][j] <= divo_dly_q[s][j-1];
				end
			end
		end
	end

	assign sd[0] = side_dly_q[0][SIDE_DLY-1];
	assign sd[1] = side_dly_q[1][SIDE_DLY-1];

	// combine stage 4: wave speed candidates
	assign ar_c = fx_add(sd[0].vx, c_w[0]);
	assign br_c = fx_add(sd[1].vx, c_w[1]);
	assign al_c = fx_sub(sd[0].vx, c_w[0]);
	assign bl_c = fx_sub(sd[1].vx, c_w[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			ar_s4 <= ar_c.v;
			br_s4 <= br_c.v;
			al_s4 <= al_c.v;
			bl_s4 <= bl_c.v;
			fl_s4 <= sd[0].f;
			fr_s4 <= sd[1].f;
			ul_s4 <= sd[0].u;
			ur_s4 <= sd[1].u;
			o_s4  <= sd[0].o | sd[1].o | divo_dly_q[0][SQRT_LAT-1]
				| divo_dly_q[1][SQRT_LAT-1] | ar_c.o | br_c.o | al_c.o | bl_c.o;
		end
	end

	// combine stage 5: wave bounds, conserved jump
	always_comb begin
		sr_c = (ar_s4 > br_s4) ? ar_s4 : br_s4;
		if (sr_c < 0) begin
			sr_c = '0;
		end
		sl_c = (al_s4 < bl_s4) ? al_s4 : bl_s4;
		if (sl_c > 0) begin
			sl_c = '0;
		end
		du_o = 1'b0;
		for (int k = 0; k < NC; k++) begin
			du_c[k] = fx_sub(ur_s4[k], ul_s4[k]);
			du_o    = du_o | du_c[k].o;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s5 <= sr_c;
			sl_s5 <= sl_c;
			fl_s5 <= fl_s4;
			fr_s5 <= fr_s4;
			for (int k = 0; k < NC; k++) begin
				du_s5[k] <= du_c[k].v;
			end
			o_s5  <= o_s4;
			oc_s5 <= du_o;
		end
	end

	// combine stage 6: weighted fluxes
	always_comb begin
		p_o = 1'b0;
		for (int k = 0; k < NC; k++) begin
			p1_c[k] = fx_mul(sr_s5, fl_s5[k]);
			p2_c[k] = fx_mul(sl_s5, fr_s5[k]);
			p_o     = p_o | p1_c[k].o | p2_c[k].o;
		end
		srsl_c = fx_mul(sr_s5, sl_s5);
		den_c  = fx_sub(sr_s5, sl_s5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				p1_s6[k] <= p1_c[k].v;
				p2_s6[k] <= p2_c[k].v;
			end
			srsl_s6 <= srsl_c.v;
			den_s6  <= den_c.v;
			du_s6   <= du_s5;
			fl_s6   <= fl_s5;
			zero_s6 <= (sr_s5 == '0) && (sl_s5 == '0);
			opre_s6 <= o_s5;
			oc_s6   <= oc_s5 | p_o | srsl_c.o | den_c.o;
		end
	end

	// combine stage 7
	always_comb begin
		m1_o = 1'b0;
		for (int k = 0; k < NC; k++) begin
			m1_c[k] = fx_sub(p1_s6[k], p2_s6[k]);
			p3_c[k] = fx_mul(srsl_s6, du_s6[k]);
			m1_o    = m1_o | m1_c[k].o | p3_c[k].o;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				m1_s7[k] <= m1_c[k].v;
				p3_s7[k] <= p3_c[k].v;
			end
			den_s7  <= den_s6;
			fl_s7   <= fl_s6;
			zero_s7 <= zero_s6;
			opre_s7 <= opre_s6;
			oc_s7   <= oc_s6 | m1_o;
		end
	end

	// combine stage 8: numerators
	always_comb begin
		m_o = 1'b0;
		for (int k = 0; k < NC; k++) begin
			m_c[k] = fx_add(m1_s7[k], p3_s7[k]);
			m_o    = m_o | m_c[k].o;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				m_s8[k] <= m_c[k].v;
			end
			den_s8  <= den_s7;
			fl_s8   <= fl_s7;
			zero_s8 <= zero_s7;
			opre_s8 <= opre_s7;
			oc_s8   <= oc_s7 | m_o;
		end
	end

	for (genvar k = 0; k < NC; k++) begin : g_comp
		hllf_div u_div (
			.clk (clk),
			.en  (en),
			.a   (m_s8[k]),
			.b   (den_s8),
			.q   (dq_w[k]),
			.ovf (do_w[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_dly_q[0].fl   <= fl_s8;
			fin_dly_q[0].zero <= zero_s8;
			fin_dly_q[0].opre <= opre_s8;
			fin_dly_q[0].oc   <= oc_s8;
			for (int j = 1; j < DIV_LAT; j++) begin
				fin_dly_q[j] <= fin_dly_q[j-1];
			end
		end
	end

	assign fin_w = fin_dly_q[DIV_LAT-1];

	// both bounds zero: left flux, no overflow from the combine
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NC; k++) begin
				flux_q[k] <= fin_w.zero ? fin_w.fl[k] : dq_w[k];
			end
			overflow_q <= fin_w.opre | (!fin_w.zero & (fin_w.oc | (|do_w)));
		end
	end

	assign flux_mass       = flux_q[0];
	assign flux_momentum_x = flux_q[1];
	assign flux_momentum_y = flux_q[2];
	assign flux_momentum_z = flux_q[3];
	assign flux_energy     = flux_q[4];
	assign overflow        = overflow_q;

endmodule

`default_nettype wire

/* hw/rtl/hllf_chk.sv */
`default_nettype none

module hllf_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [hllf_pkg::DW-1:0] flux_mass
);

	// held result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(flux_mass))
		else $error("stalled result changed");

	// input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_free_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |-> !in_stall)
		else $error("input stalled while result is taken");

endmodule

bind hll_euler_interface_flux_unit hllf_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.flux_mass (flux_mass)
);

`default_nettype wire
